### rtl/gated_nearest_point_matcher_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gated nearest point matcher
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GATED_NEAREST_POINT_MATCHER_MACROS_SVH
`define GATED_NEAREST_POINT_MATCHER_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge out of reset.
`define GNPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("gnpm: assertion failed");

// Check that the consequent holds in the cycle of the antecedent.
`define GNPM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gnpm: implication failed");

`else

`define GNPM_ASSERT(lbl, prop)
`define GNPM_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

### rtl/gnpm_pkg.sv
// ----------------------------------------------------------------------------
// gnpm_pkg
// Shared sizes, codes and types of the gated nearest point matcher.
// ----------------------------------------------------------------------------
package gnpm_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int COORD_W     = 16;

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * COORD_W + 1;
  localparam int DIST_W = SQ_W + 1;

  localparam int GATE_W     = 16;
  localparam int GATE_SQ_W  = 2 * GATE_W;
  localparam int CMP_W      = (DIST_W > GATE_SQ_W) ? DIST_W : GATE_SQ_W;
  localparam int QNUM_W     = 16;
  localparam int OP_W       = 2;

  localparam logic [GATE_W-1:0] GATE_RESET = '1;
  localparam logic [QNUM_W-1:0] QUERY_MAX  = '1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } gnpm_op_e;

  // Tag that travels with one table read through the distance pipeline.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } gnpm_tag_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] sq_dist;
  } gnpm_dist_t;

endpackage

### rtl/gnpm_ref_mem.sv
// ----------------------------------------------------------------------------
// gnpm_ref_mem
// Reference point table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gnpm_ref_mem (
  input  logic                               clk_i,
  input  logic                               wr_en_i,
  input  logic [gnpm_pkg::IDX_W-1:0]         wr_addr_i,
  input  logic signed [gnpm_pkg::COORD_W-1:0] wr_x_i,
  input  logic signed [gnpm_pkg::COORD_W-1:0] wr_y_i,
  input  logic                               rd_en_i,
  input  logic [gnpm_pkg::IDX_W-1:0]         rd_addr_i,
  output logic signed [gnpm_pkg::COORD_W-1:0] rd_x_o,
  output logic signed [gnpm_pkg::COORD_W-1:0] rd_y_o
);
  import gnpm_pkg::*;

  logic [2*COORD_W-1:0] mem_q [TABLE_DEPTH];
  logic [2*COORD_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_x_i, wr_y_i};
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_x_o = $signed(rd_q[2*COORD_W-1:COORD_W]);
  assign rd_y_o = $signed(rd_q[COORD_W-1:0]);

endmodule

### rtl/gnpm_dist_unit.sv
// ----------------------------------------------------------------------------
// gnpm_dist_unit
// Pipelined squared distance unit: difference, square, sum; one point a cycle.
// ----------------------------------------------------------------------------
module gnpm_dist_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gnpm_pkg::gnpm_tag_t                 tag_i,
  input  logic signed [gnpm_pkg::COORD_W-1:0] ref_x_i,
  input  logic signed [gnpm_pkg::COORD_W-1:0] ref_y_i,
  input  logic signed [gnpm_pkg::COORD_W-1:0] qry_x_i,
  input  logic signed [gnpm_pkg::COORD_W-1:0] qry_y_i,
  output gnpm_pkg::gnpm_dist_t                res_o
);
  import gnpm_pkg::*;

  gnpm_tag_t tag1_q, tag2_q;
  logic signed [DIFF_W-1:0] dx_d, dy_d, dx_q, dy_q;
  logic signed [2*DIFF_W-1:0] px, py;
  logic [SQ_W-1:0] sqx_q, sqy_q;
  logic              res_valid_q, res_last_q;
  logic [IDX_W-1:0]  res_idx_q;
  logic [DIST_W-1:0] res_sq_q;

  assign dx_d = $signed({ref_x_i[COORD_W-1], ref_x_i}) - $signed({qry_x_i[COORD_W-1], qry_x_i});
  assign dy_d = $signed({ref_y_i[COORD_W-1], ref_y_i}) - $signed({qry_y_i[COORD_W-1], qry_y_i});

  assign px = dx_q * dx_q;
  assign py = dy_q * dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q      <= '0;
      tag2_q      <= '0;
      res_valid_q <= 1'b0;
      res_last_q  <= 1'b0;
    end else begin
      tag1_q      <= tag_i;
      tag2_q      <= tag1_q;
      res_valid_q <= tag2_q.valid;
      res_last_q  <= tag2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    sqx_q     <= px[SQ_W-1:0];
    sqy_q     <= py[SQ_W-1:0];
    res_idx_q <= tag2_q.idx;
    res_sq_q  <= DIST_W'(sqx_q) + DIST_W'(sqy_q);
  end

  always_comb begin
    res_o.valid   = res_valid_q;
    res_o.last    = res_last_q;
    res_o.idx     = res_idx_q;
    res_o.sq_dist = res_sq_q;
  end

endmodule

### rtl/gated_nearest_point_matcher.sv
// ----------------------------------------------------------------------------
// gated_nearest_point_matcher
// Nearest reference point search with a squared distance gate.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   operation_i, point_x_i, point_y_i
//   out      output     out_valid_o / out_ready_i query_number_o, matched_index_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (gate distance)
//
// Clear, load and a query on an empty table leave the block idle for the next request.
// A query scans all N stored points in order, lowest index first:
// one table read port feeds the distance pipeline one point a cycle.
// Reset clears the point count and query count and opens the gate fully;
// table contents stay undefined until loaded. A waiting result does not
// block new requests; a finishing query holds until the output register is free.
// ----------------------------------------------------------------------------
`include "gated_nearest_point_matcher_macros.svh"

module gated_nearest_point_matcher (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [gnpm_pkg::OP_W-1:0]           operation_i,
  input  logic signed [gnpm_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [gnpm_pkg::COORD_W-1:0] point_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [gnpm_pkg::QNUM_W-1:0]         query_number_o,
  output logic [gnpm_pkg::IDX_W-1:0]          matched_index_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gnpm_pkg::GATE_W-1:0]         cfg_data_i
);
  import gnpm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic [GATE_W-1:0]    gate_q, gate_d;
  logic [GATE_SQ_W-1:0] gate_sq_q, gate_sq_d;
  logic [CNT_W-1:0]     ref_cnt_q, ref_cnt_d;
  logic [QNUM_W-1:0]    query_cnt_q, query_cnt_d;
  logic [QNUM_W-1:0]    qnum_q, qnum_d;
  logic signed [COORD_W-1:0] qx_q, qx_d, qy_q, qy_d;
  logic [IDX_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 issuing_q, issuing_d;
  gnpm_tag_t            tag_q, tag_d;
  logic                 found_q, found_d;
  logic [DIST_W-1:0]    best_q, best_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  logic                 out_valid_q, out_valid_d;
  logic [QNUM_W-1:0]    out_qnum_q, out_qnum_d;
  logic [IDX_W-1:0]     out_idx_q, out_idx_d;

  logic mem_we, mem_re;
  logic signed [COORD_W-1:0] rd_x, rd_y;
  gnpm_dist_t res;

  assign in_ready_o      = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign query_number_o  = out_qnum_q;
  assign matched_index_o = out_idx_q;

  always_comb begin
    state_d     = state_q;
    gate_d      = gate_q;
    gate_sq_d   = gate_sq_q;
    ref_cnt_d   = ref_cnt_q;
    query_cnt_d = query_cnt_q;
    qnum_d      = qnum_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    rd_idx_d    = rd_idx_q;
    issuing_d   = issuing_q;
    tag_d       = '0;
    found_d     = found_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    out_valid_d = out_valid_q;
    out_qnum_d  = out_qnum_q;
    out_idx_d   = out_idx_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    if (cfg_valid_i) begin
      gate_d = cfg_data_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (gnpm_op_e'(operation_i))
            OP_CLEAR: begin
              ref_cnt_d   = '0;
              query_cnt_d = '0;
            end
            OP_LOAD: begin
              if (ref_cnt_q < CNT_W'(TABLE_DEPTH)) begin
                mem_we    = 1'b1;
                ref_cnt_d = CNT_W'(ref_cnt_q + 1'b1);
              end
            end
            OP_QUERY: begin
              qnum_d = query_cnt_q;
              if (query_cnt_q != QUERY_MAX) begin
                query_cnt_d = QNUM_W'(query_cnt_q + 1'b1);
              end
              qx_d      = point_x_i;
              qy_d      = point_y_i;
              gate_sq_d = GATE_SQ_W'(gate_q) * GATE_SQ_W'(gate_q);
              // empty table: count the query, emit nothing
              if (ref_cnt_q != '0) begin
                state_d   = ST_SCAN;
                rd_idx_d  = '0;
                issuing_d = 1'b1;
                found_d   = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (issuing_q) begin
          mem_re      = 1'b1;
          tag_d.valid = 1'b1;
          tag_d.idx   = rd_idx_q;
          tag_d.last  = (CNT_W'(rd_idx_q) == CNT_W'(ref_cnt_q - 1'b1));
          if (tag_d.last) begin
            issuing_d = 1'b0;
          end else begin
            rd_idx_d = IDX_W'(rd_idx_q + 1'b1);
          end
        end
        // strict compare keeps the lowest index on a tie
        if (res.valid) begin
          if (!found_q || (res.sq_dist < best_q)) begin
            found_d    = 1'b1;
            best_d     = res.sq_dist;
            best_idx_d = res.idx;
          end
          if (res.last) begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          if (CMP_W'(best_q) <= CMP_W'(gate_sq_q)) begin
            out_valid_d = 1'b1;
            out_qnum_d  = qnum_q;
            out_idx_d   = best_idx_q;
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gate_q      <= GATE_RESET;
      ref_cnt_q   <= '0;
      query_cnt_q <= '0;
      issuing_q   <= 1'b0;
      tag_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gate_q      <= gate_d;
      ref_cnt_q   <= ref_cnt_d;
      query_cnt_q <= query_cnt_d;
      issuing_q   <= issuing_d;
      tag_q       <= tag_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gate_sq_q  <= gate_sq_d;
    qnum_q     <= qnum_d;
    qx_q       <= qx_d;
    qy_q       <= qy_d;
    rd_idx_q   <= rd_idx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    out_qnum_q <= out_qnum_d;
    out_idx_q  <= out_idx_d;
  end

  gnpm_ref_mem u_ref_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (ref_cnt_q[IDX_W-1:0]),
    .wr_x_i    (point_x_i),
    .wr_y_i    (point_y_i),
    .rd_en_i   (mem_re),
    .rd_addr_i (rd_idx_q),
    .rd_x_o    (rd_x),
    .rd_y_o    (rd_y)
  );

  gnpm_dist_unit u_dist_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag_q),
    .ref_x_i (rd_x),
    .ref_y_i (rd_y),
    .qry_x_i (qx_q),
    .qry_y_i (qy_q),
    .res_o   (res)
  );

  `GNPM_ASSERT(a_cnt_bounded, ref_cnt_q <= CNT_W'(TABLE_DEPTH))
  `GNPM_ASSERT_IMPL(a_scan_read_in_range, (state_q == ST_SCAN) && issuing_q,
                    CNT_W'(rd_idx_q) < ref_cnt_q)
  `GNPM_ASSERT_IMPL(a_result_only_in_scan, res.valid, state_q == ST_SCAN)
  `GNPM_ASSERT_IMPL(a_finish_has_best, state_q == ST_FINISH, found_q)
  `GNPM_ASSERT(a_query_cnt_steps, (query_cnt_q == $past(query_cnt_q)) ||
               (query_cnt_q == QNUM_W'($past(query_cnt_q) + 1'b1)) || (query_cnt_q == '0))

endmodule
